### rtl/npff_pkg.sv
// ----------------------------------------------------------------------------
// npff_pkg
// Shared types and codes for the fixed-first next-permutation unit.
// ----------------------------------------------------------------------------
package npff_pkg;

    localparam int VAL_W = 4;

    typedef enum logic [1:0] {
        KIND_RESTORE = 2'd0,
        KIND_LOAD    = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // per-cell command, the same for the whole row
    typedef enum logic [2:0] {
        CMD_HOLD  = 3'd0,
        CMD_RESET = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_SWAP  = 3'd3,
        CMD_SHIFT = 3'd4
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [5:0]       idx_a;
        logic [5:0]       idx_b;
        logic [VAL_W-1:0] val_a;
        logic [VAL_W-1:0] val_b;
    } cell_ctl_t;

    localparam int CFG_SIZE_IN_USE = 0;

endpackage

### rtl/npff_cell.sv
// ----------------------------------------------------------------------------
// npff_cell
// One entry of the permutation row: holds a vertex id, takes load, swap
// and rotate commands, and passes its value to the left neighbor.
// ----------------------------------------------------------------------------
module npff_cell
    import npff_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [VAL_W-1:0] right_in,
    output logic [VAL_W-1:0] value
);
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        case (ctl.cmd)
            CMD_RESET: value_next = VAL_W'(IDX);
            CMD_LOAD: begin
                if (ctl.idx_a == 6'(IDX)) value_next = ctl.val_a;
            end
            CMD_SWAP: begin
                if (ctl.idx_a == 6'(IDX)) value_next = ctl.val_b;
                else if (ctl.idx_b == 6'(IDX)) value_next = ctl.val_a;
            end
            CMD_SHIFT: value_next = right_in;
            default: value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= VAL_W'(IDX);
        end else begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;
endmodule

### rtl/next_permutation_fixed_first_unit.sv
// restore/load update the cell row from idle; advance scans the suffix for the pivot,
// selects the swap partner, swaps, reverses the suffix and emits n words by
// rotating the cell row, one word a cycle while m_tready is high,
// one item at a time; the next word is taken once the run is delivered
// reset: synchronous active low, store returns to identity, size to 16
// ----------------------------------------------------------------------------
// next_permutation_fixed_first_unit
// Steps a permutation to its lexicographic successor keeping position 0.
// ----------------------------------------------------------------------------
module next_permutation_fixed_first_unit
    import npff_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // kind[1:0], entry_index[5:2], entry_value[9:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // position[3:0], vertex[7:4]
    output logic        m_tlast,
    output logic        m_tuser,   // exhausted
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int N = MAX_VERTICES;
    localparam int IW = $clog2(N);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCANP = 7'b0000010,
        ST_SCANS = 7'b0000100,
        ST_SWAP  = 7'b0001000,
        ST_REV   = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_EXH   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] size_reg;
    logic [5:0] n_reg, p_reg, s_reg, cnt_reg;
    logic [5:0] n_eff;
    logic [VAL_W-1:0] vals [N];
    cell_ctl_t ctl;

    logic [1:0] in_kind;
    logic [3:0] in_idx, in_val;
    assign in_kind = s_tdata[1:0];
    assign in_idx  = s_tdata[5:2];
    assign in_val  = s_tdata[9:6];

    assign pready = 1'b1;
    assign prdata = {27'd0, size_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) size_reg <= 5'd16;
        else if (psel && penable && pwrite && paddr == 2'(CFG_SIZE_IN_USE))
            size_reg <= pwdata[4:0];
    end

    always_comb begin
        n_eff = 6'(size_reg);
        if (n_eff > 6'(N)) n_eff = 6'(N);
        if (n_eff > 6'd16) n_eff = 6'd16;
    end

    // row of cells; rotation feeds cell 0 into the top cell in use
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic [VAL_W-1:0] rin;
            if (g == N-1) begin : g_top
                assign rin = (n_reg == 6'(N)) ? vals[0] : vals[g];
            end else begin : g_mid
                assign rin = (6'(g) == n_reg - 6'd1) ? vals[0] :
                             (6'(g) >= n_reg) ? vals[g] : vals[g+1];
            end
            npff_cell #(.IDX(g)) u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
                .right_in(rin), .value(vals[g])
            );
        end
    endgenerate

    logic [VAL_W-1:0] vp, vpm1, vs;
    assign vp   = vals[p_reg[IW-1:0]];
    assign vpm1 = vals[IW'(p_reg - 6'd1)];
    assign vs   = vals[s_reg[IW-1:0]];

    logic [5:0] p_next, s_next, cnt_next, n_next;
    always_comb begin
        state_next = state_reg;
        p_next = p_reg; s_next = s_reg; cnt_next = cnt_reg; n_next = n_reg;
        ctl = '0;
        ctl.cmd = CMD_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_kind)
                        KIND_RESTORE: ctl.cmd = CMD_RESET;
                        KIND_LOAD: begin
                            ctl.cmd = CMD_LOAD;
                            ctl.idx_a = 6'(in_idx);
                            ctl.val_a = in_val;
                            if (32'(in_idx) >= N) ctl.cmd = CMD_HOLD;
                        end
                        KIND_ADVANCE: begin
                            n_next = n_eff;
                            p_next = n_eff - 6'd1;
                            state_next = (n_eff >= 6'd3) ? ST_SCANP : ST_EXH;
                        end
                        default: ctl.cmd = CMD_HOLD;
                    endcase
                end
            end
            ST_SCANP: begin
                if (p_reg > 6'd1 && vpm1 >= vp) p_next = p_reg - 6'd1;
                else if (p_reg > 6'd1) begin
                    s_next = n_reg - 6'd1;
                    state_next = ST_SCANS;
                end else state_next = ST_EXH;
            end
            ST_SCANS: begin
                if (s_reg > p_reg && vs <= vpm1) s_next = s_reg - 6'd1;
                else state_next = ST_SWAP;
            end
            ST_SWAP: begin
                ctl.cmd = CMD_SWAP;
                ctl.idx_a = p_reg - 6'd1; ctl.idx_b = s_reg;
                ctl.val_a = vpm1; ctl.val_b = vs;
                s_next = n_reg - 6'd1;
                state_next = ST_REV;
            end
            ST_REV: begin
                if (p_reg < s_reg) begin
                    ctl.cmd = CMD_SWAP;
                    ctl.idx_a = p_reg; ctl.idx_b = s_reg;
                    ctl.val_a = vp; ctl.val_b = vs;
                    p_next = p_reg + 6'd1; s_next = s_reg - 6'd1;
                end else begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    ctl.cmd = CMD_SHIFT;
                    cnt_next = cnt_reg + 6'd1;
                    if (cnt_reg == n_reg - 6'd1) state_next = ST_IDLE;
                end
            end
            ST_EXH: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg <= 6'd16; p_reg <= '0; s_reg <= '0; cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            n_reg <= n_next; p_reg <= p_next; s_reg <= s_next; cnt_reg <= cnt_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT) || (state_reg == ST_EXH);
    assign m_tdata  = (state_reg == ST_EMIT) ? {vals[0], cnt_reg[3:0]} : 8'd0;
    assign m_tlast  = (state_reg == ST_EXH) || (cnt_reg == n_reg - 6'd1);
    assign m_tuser  = (state_reg == ST_EXH);
endmodule

### rtl/npff_checker.sv
// ----------------------------------------------------------------------------
// npff_checker
// Port-level checks for the next-permutation unit, bound to the top level.
// ----------------------------------------------------------------------------
module npff_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);
    // an exhausted word is a lone zero word closing its run
    a_exh: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && m_tdata == 8'd0)
        else $error("exhausted word malformed");

    // no input taken while a run is on the output
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready during output run");

    // a run starts at position zero
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> m_tdata[3:0] == 4'd0)
        else $error("run does not start at position zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled word changed");
endmodule

bind next_permutation_fixed_first_unit npff_checker u_npff_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
);
